@@ src/odrgb_pkg.sv @@
package odrgb_pkg;

   localparam int unsigned ChannelWidth = 8;
   localparam int unsigned WidthBits    = 12;
   localparam int unsigned DitherBits   = 4;
   localparam int unsigned PixelBits    = 16;

   localparam logic [WidthBits-1:0] WidthReset = 12'd1;

   localparam logic [15:0] DitherRows [4] = '{16'h5140, 16'h3726, 16'h4051, 16'h2637};

   typedef struct packed {
      logic [ChannelWidth-1:0] red;
      logic [ChannelWidth-1:0] green;
      logic [ChannelWidth-1:0] blue;
   } color_type;

   typedef struct packed {
      color_type             color;
      logic [DitherBits-1:0] dither;
   } stage_type;

endpackage

@@ src/ordered_dither_rgb888_to_rgb565.sv @@
// an accepted request is held in the input register, then in the response register
// throughput: one request per cycle while rsp_stall is low, set by the input and response registers
// a stalled response stage backs up into the input register, then into req_stall
// reset (synchronous, active high) empties both stages, clears column and row,
// and sets the image width to one
module ordered_dither_rgb888_to_rgb565 (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [odrgb_pkg::WidthBits-1:0]       csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [odrgb_pkg::ChannelWidth-1:0]    req_red,
   input  logic [odrgb_pkg::ChannelWidth-1:0]    req_green,
   input  logic [odrgb_pkg::ChannelWidth-1:0]    req_blue,
   input  logic                                  req_start_of_frame,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [odrgb_pkg::PixelBits-1:0]       rsp_pixel_rgb565
);

   logic                                s1_valid_ff;
   logic                                s1_valid_in;
   odrgb_pkg::stage_type                s1_data_ff;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic [odrgb_pkg::PixelBits-1:0]     rsp_pixel_ff;
   logic [odrgb_pkg::PixelBits-1:0]     pixel;
   logic [odrgb_pkg::DitherBits-1:0]    dither;
   logic                                out_load;
   logic                                s1_load;
   logic                                accept;

   odrgb_position u_position (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .start_of_frame   (req_start_of_frame),
      .dither           (dither)
   );

   odrgb_convert u_convert (
      .stage (s1_data_ff),
      .pixel (pixel)
   );

   always_comb begin
      out_load     = !rsp_valid_ff || !rsp_stall;
      s1_load      = !s1_valid_ff || out_load;
      req_stall    = !s1_load;
      accept       = req_valid && s1_load;
      s1_valid_in  = s1_load ? req_valid : s1_valid_ff;
      rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= '{color: '{red: req_red, green: req_green, blue: req_blue},
                         dither: dither};
      end
      if (out_load && s1_valid_ff) begin
         rsp_pixel_ff <= pixel;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_rgb565 = rsp_pixel_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("request stalled while a stage was free");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_load |=> rsp_valid_ff)
      else $error("input stage item lost on the way to the response");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_load |=> s1_valid_ff && $stable(s1_data_ff))
      else $error("input stage changed while blocked");

endmodule

@@ src/odrgb_position.sv @@
module odrgb_position (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [odrgb_pkg::WidthBits-1:0]     csr_write_data,
   input  logic                                accept,
   input  logic                                start_of_frame,
   output logic [odrgb_pkg::DitherBits-1:0]    dither
);

   logic [odrgb_pkg::WidthBits-1:0] width_ff;
   logic [odrgb_pkg::WidthBits-1:0] column_ff;
   logic [odrgb_pkg::WidthBits-1:0] column_in;
   logic [1:0]                      row_ff;
   logic [1:0]                      row_in;
   logic [odrgb_pkg::WidthBits-1:0] column_now;
   logic [1:0]                      row_now;
   logic [odrgb_pkg::WidthBits:0]   column_next;
   logic [15:0]                     row_word;

   always_comb begin
      column_now = start_of_frame ? '0 : column_ff;
      row_now    = start_of_frame ? '0 : row_ff;
      row_word   = odrgb_pkg::DitherRows[row_now];
      unique case (column_now[1:0])
         2'd0: dither = row_word[3:0];
         2'd1: dither = row_word[7:4];
         2'd2: dither = row_word[11:8];
         default: dither = row_word[15:12];
      endcase
      column_next = {1'b0, column_now} + 13'd1;
      column_in   = column_next[odrgb_pkg::WidthBits-1:0];
      row_in      = row_now;
      // wrap at end of row, also when the width was lowered mid-row
      if (column_in >= width_ff) begin
         column_in = '0;
         row_in    = row_now + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= odrgb_pkg::WidthReset;
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         if (accept) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
      end
   end

endmodule

@@ src/odrgb_convert.sv @@
module odrgb_convert (
   input  odrgb_pkg::stage_type              stage,
   output logic [odrgb_pkg::PixelBits-1:0]   pixel
);

   logic [8:0] red_sum;
   logic [8:0] green_sum;
   logic [8:0] blue_sum;
   logic [7:0] red_sat;
   logic [7:0] green_sat;
   logic [7:0] blue_sat;

   always_comb begin
      red_sum   = {1'b0, stage.color.red} + 9'(stage.dither)
                  - 9'(stage.color.red[7:5]);
      green_sum = {1'b0, stage.color.green} + 9'(stage.dither[3:1])
                  - 9'(stage.color.green[7:6]);
      blue_sum  = {1'b0, stage.color.blue} + 9'(stage.dither)
                  - 9'(stage.color.blue[7:5]);
      red_sat   = red_sum[8]   ? 8'hFF : red_sum[7:0];
      green_sat = green_sum[8] ? 8'hFF : green_sum[7:0];
      blue_sat  = blue_sum[8]  ? 8'hFF : blue_sum[7:0];
      pixel     = {red_sat[7:3], green_sat[7:2], blue_sat[7:3]};
   end

endmodule

@@ dv/ordered_dither_rgb888_to_rgb565_tb.sv @@
module ordered_dither_rgb888_to_rgb565_tb;

   localparam int unsigned CycleLimit = 400000;
   localparam logic [15:0] BayerRows [4] = '{16'h5140, 16'h3726, 16'h4051, 16'h2637};

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_write_enable = 1'b0;
   logic [odrgb_pkg::WidthBits-1:0]     csr_write_data = '0;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [odrgb_pkg::ChannelWidth-1:0]  req_red = '0;
   logic [odrgb_pkg::ChannelWidth-1:0]  req_green = '0;
   logic [odrgb_pkg::ChannelWidth-1:0]  req_blue = '0;
   logic                                req_start_of_frame = 1'b0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [odrgb_pkg::PixelBits-1:0]     rsp_pixel_rgb565;

   logic [odrgb_pkg::WidthBits-1:0]     model_width = odrgb_pkg::WidthReset;
   logic [odrgb_pkg::WidthBits-1:0]     model_column = '0;
   logic [1:0]                          model_row = '0;
   logic [odrgb_pkg::PixelBits-1:0]     expected_pixels [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int width_writes = 0;
   int mismatch_count = 0;
   int unsigned cycle_count = 0;

   ordered_dither_rgb888_to_rgb565 dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .req_start_of_frame (req_start_of_frame),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_rgb565   (rsp_pixel_rgb565)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL ordered_dither_rgb888_to_rgb565");
         $finish;
      end
   end

   function automatic logic [7:0] dither_saturate(input logic [7:0] value, input logic [3:0] bump,
                                                  input int shift);
      int sum;
      sum = value + bump - (value >> shift);
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // convert one pixel at the tracked position, then advance the position
   task automatic predict_pixel(input logic [7:0] red, input logic [7:0] green,
                                input logic [7:0] blue, input logic start_of_frame);
      logic [3:0] dither;
      logic [7:0] red_sat, green_sat, blue_sat;
      if (start_of_frame) begin
         model_column = '0;
         model_row = '0;
      end
      dither = BayerRows[model_row][model_column[1:0]*4 +: 4];
      red_sat = dither_saturate(red, dither, 5);
      green_sat = dither_saturate(green, dither >> 1, 6);
      blue_sat = dither_saturate(blue, dither, 5);
      expected_pixels.push_back({red_sat[7:3], green_sat[7:2], blue_sat[7:3]});
      model_column = model_column + 1'b1;
      if (model_column >= model_width) begin
         model_column = '0;
         model_row = model_row + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_pixels.size() == 0) begin
            $error("unexpected response, pixel_rgb565 %h", rsp_pixel_rgb565);
            mismatch_count++;
         end else begin
            if (rsp_pixel_rgb565 !== expected_pixels[0]) begin
               $error("pixel_rgb565 expected %h actual %h", expected_pixels[0], rsp_pixel_rgb565);
               mismatch_count++;
            end
            void'(expected_pixels.pop_front());
            pixels_checked++;
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
   end

   // called just after a rising edge; returns just after the edge that takes the request
   task automatic send_pixel(input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue, input logic start_of_frame);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= red;
      req_green <= green;
      req_blue <= blue;
      req_start_of_frame <= start_of_frame;
      do @(posedge clock); while (req_stall);
      predict_pixel(red, green, blue, start_of_frame);
      pixels_sent++;
   endtask

   task automatic write_image_width(input logic [odrgb_pkg::WidthBits-1:0] width);
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= width;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_width = width;
      width_writes++;
   endtask

   function automatic logic [7:0] random_channel();
      case ($urandom_range(0, 7))
         0: return 8'd255 - 8'($urandom_range(0, 15));
         1: return 8'($urandom_range(0, 7));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // frames of random length with a few stray start-of-frame flags
   task automatic send_frames(input int count);
      int frame_left;
      logic start_of_frame;
      frame_left = 0;
      for (int i = 0; i < count; i++) begin
         start_of_frame = (frame_left == 0) || ($urandom_range(0, 49) == 0);
         if (frame_left == 0) frame_left = $urandom_range(4, 160);
         frame_left--;
         send_pixel(random_channel(), random_channel(), random_channel(), start_of_frame);
      end
   endtask

   task automatic test_directed_corners();
      send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
      send_pixel(8'd255, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 1'b0);
      send_pixel(8'd250, 8'd252, 8'd249, 1'b0);
      send_pixel(8'd31, 8'd63, 8'd32, 1'b0);
      send_pixel(8'hAA, 8'h55, 8'hAA, 1'b1);
      send_pixel(8'h55, 8'hAA, 8'h55, 1'b0);
      // width lowered mid-row
      write_image_width(12'd8);
      send_pixel(8'd128, 8'd128, 8'd128, 1'b1);
      for (int i = 0; i < 4; i++) send_pixel(8'd200, 8'd100, 8'd50, 1'b0);
      write_image_width(12'd3);
      send_pixel(8'd7, 8'd7, 8'd7, 1'b0);
      send_pixel(8'd254, 8'd254, 8'd254, 1'b0);
      // zero width behaves like one
      write_image_width(12'd0);
      for (int i = 0; i < 3; i++) send_pixel(8'd120, 8'd121, 8'd122, 1'b0);
      // start of frame in the middle of a row
      write_image_width(12'd4);
      send_pixel(8'd64, 8'd64, 8'd64, 1'b0);
      send_pixel(8'd65, 8'd66, 8'd67, 1'b0);
      send_pixel(8'd68, 8'd69, 8'd70, 1'b0);
      send_pixel(8'd71, 8'd72, 8'd73, 1'b1);
      send_pixel(8'd74, 8'd75, 8'd76, 1'b0);
      send_pixel(8'd77, 8'd78, 8'd79, 1'b0);
   endtask

   task automatic test_short_rows();
      for (int width = 1; width <= 8; width++) begin
         write_image_width(12'(width));
         send_frames(46);
      end
   endtask

   task automatic test_random_widths();
      for (int i = 0; i < 6; i++) begin
         write_image_width(12'($urandom_range(1, 64)));
         send_frames(64);
      end
   endtask

   task automatic test_wide_rows();
      write_image_width(12'd4095);
      send_frames(95);
      write_image_width(12'd0);
      send_frames(95);
      write_image_width(12'($urandom_range(1, 4095)));
      send_frames(95);
      write_image_width(12'd2048);
      send_frames(95);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 34;
      recv_idle_pct = 77;
      test_directed_corners();
      test_short_rows();
      send_idle_pct = 77;
      recv_idle_pct = 34;
      test_random_widths();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_wide_rows();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("sent %0d pixels, checked %0d converted words", pixels_sent, pixels_checked);
      $display("image width written %0d times, zero and 4095 among them", width_writes);
      if (mismatch_count == 0) begin
         $display("PASS ordered_dither_rgb888_to_rgb565");
      end else begin
         $display("FAIL ordered_dither_rgb888_to_rgb565");
      end
      $finish;
   end

endmodule

@@ ordered_dither_rgb888_to_rgb565.f @@
src/odrgb_pkg.sv
src/odrgb_position.sv
src/odrgb_convert.sv
src/ordered_dither_rgb888_to_rgb565.sv
dv/ordered_dither_rgb888_to_rgb565_tb.sv
